// File: design/gpq_pkg.sv
// ----------------------------------------------------------------------------
// gpq_pkg
// Shared types, constants and phase-update functions for the gamepad input
// qualifier.
// ----------------------------------------------------------------------------
package gpq_pkg;

  // Stream and field widths
  localparam int IN_W        = 112;  // input tdata, padded to whole bytes
  localparam int OUT_W       = 56;   // output tdata, padded to whole bytes
  localparam int LEVEL_W     = 15;
  localparam int AXIS_W      = 16;
  localparam int CFG_INDEX_W = 8;

  // Channels carried by the snapshot and by the result
  localparam int IN_BUTTONS  = 16;
  localparam int IN_TRIGGERS = 2;
  localparam int IN_AXES     = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LEVEL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_LEVEL  = 8'd1;

  localparam logic [LEVEL_W-1:0] PRESS_LEVEL_RESET = 15'd16383;
  localparam logic [LEVEL_W-1:0] DEAD_LEVEL_RESET  = 15'd6553;

  typedef enum logic [1:0] {
    KP_IDLE   = 2'd0,
    KP_DOWN   = 2'd1,
    KP_REPEAT = 2'd2,
    KP_UP     = 2'd3
  } key_phase_t;

  typedef enum logic [2:0] {
    AX_IDLE        = 3'd0,
    AX_POS_DOWN    = 3'd1,
    AX_POS_REPEAT  = 3'd2,
    AX_POS_RELEASE = 3'd3,
    AX_NEG_DOWN    = 3'd4,
    AX_NEG_REPEAT  = 3'd5,
    AX_NEG_RELEASE = 3'd6
  } axis_phase_t;

  // Snapshot as packed on the input stream, last field in the low bits
  typedef struct packed {
    logic [IN_AXES-1:0][AXIS_W-1:0]      stick_value;
    logic [IN_TRIGGERS-1:0][LEVEL_W-1:0] trigger_level;
    logic [IN_BUTTONS-1:0]               button_bits;
    logic                                connected;
  } snapshot_t;

  // Result as packed on the output stream, last field in the low bits
  typedef struct packed {
    logic [IN_AXES-1:0][2:0]     axis_code;
    logic [IN_TRIGGERS-1:0][1:0] trigger_code;
    logic [2*IN_BUTTONS-1:0]     button_codes;
    logic                        is_connected;
  } result_t;

  function automatic key_phase_t key_next(key_phase_t ph, logic pressed);
    key_phase_t r;
    if (pressed) begin
      r = (ph == KP_IDLE) ? KP_DOWN : KP_REPEAT;
    end else if (ph == KP_DOWN || ph == KP_REPEAT) begin
      r = KP_UP;
    end else begin
      r = KP_IDLE;
    end
    return r;
  endfunction

  function automatic axis_phase_t axis_next(axis_phase_t ph, logic pos, logic neg,
                                            logic centered);
    axis_phase_t r;
    r = ph;
    if (pos) begin
      r = (ph == AX_IDLE) ? AX_POS_DOWN : AX_POS_REPEAT;
    end else if (neg) begin
      r = (ph == AX_IDLE) ? AX_NEG_DOWN : AX_NEG_REPEAT;
    end else if (centered) begin
      case (ph) inside
        AX_POS_DOWN, AX_POS_REPEAT: r = AX_POS_RELEASE;
        AX_NEG_DOWN, AX_NEG_REPEAT: r = AX_NEG_RELEASE;
        default:                    r = AX_IDLE;
      endcase
    end
    return r;
  endfunction

endpackage

// File: design/gpq_key_bank.sv
// ----------------------------------------------------------------------------
// gpq_key_bank
// Phase registers and next-phase logic for a bank of digital keys
// (buttons, or triggers already compared against the press level).
// ----------------------------------------------------------------------------
module gpq_key_bank import gpq_pkg::*; #(
  parameter int N = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  logic [N-1:0] pressed,
  output key_phase_t phase_next [N]
);

  key_phase_t phase [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      phase_next[i] = key_next(phase[i], pressed[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) phase[i] <= KP_IDLE;
    end else if (update) begin
      for (int i = 0; i < N; i++) phase[i] <= phase_next[i];
    end
  end

endmodule

// File: design/gpq_axis_bank.sv
// ----------------------------------------------------------------------------
// gpq_axis_bank
// Phase registers, dead-zone and press-level classification for a bank of
// signed stick axes.
// ----------------------------------------------------------------------------
module gpq_axis_bank import gpq_pkg::*; #(
  parameter int N = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  logic [N-1:0][AXIS_W-1:0] value,
  input  logic [LEVEL_W-1:0]       press_level,
  input  logic [LEVEL_W-1:0]       dead_level,
  output axis_phase_t              phase_next [N]
);

  axis_phase_t phase [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [AXIS_W:0] vext;
      logic [AXIS_W:0] mag;
      logic            centered;
      logic            over;
      vext     = {value[i][AXIS_W-1], value[i]};
      // magnitude of a 16-bit value fits 17 bits unsigned (up to 32768)
      mag      = value[i][AXIS_W-1] ? ((AXIS_W+1)'(0) - vext) : vext;
      centered = mag < {2'b00, dead_level};
      over     = mag > {2'b00, press_level};
      // a centered value is zeroed and so is never beyond the press level;
      // after zeroing, "inside the dead zone" is the centered test itself
      phase_next[i] = axis_next(phase[i],
                                !centered && !value[i][AXIS_W-1] && over,
                                !centered && value[i][AXIS_W-1] && over,
                                centered);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) phase[i] <= AX_IDLE;
    end else if (update) begin
      for (int i = 0; i < N; i++) phase[i] <= phase_next[i];
    end
  end

endmodule

// File: design/gamepad_input_qualifier_top.sv
// ----------------------------------------------------------------------------
// gamepad_input_qualifier_top
// Gamepad snapshot qualifier: button and trigger edge phases, stick dead zone
// and press-level phases, one result per snapshot.
// ----------------------------------------------------------------------------
// Each snapshot transfer on the input stream yields exactly one result
// transfer on the output stream. The block takes one snapshot per cycle at
// full rate while the output is not stalled. A snapshot passes through the
// input register, then the per-channel phase update, then the result
// register. Button, trigger and axis phases advance only on connected
// snapshots; a disconnected snapshot leaves them untouched and reports
// is_connected = 0 with every code 0. All phases reset to idle.
// press_level and dead_level are written through the config port (index 0
// and 1) and must only change while no snapshot is in flight. Buttons beyond
// the sixteen input bits read as released, triggers and axes beyond the
// snapshot read as zero; only the channels that fit the result fields are
// reported.
// ----------------------------------------------------------------------------
module gamepad_input_qualifier_top import gpq_pkg::*; #(
  parameter int NUM_BUTTONS  = 16,
  parameter int NUM_TRIGGERS = 2,
  parameter int NUM_AXES     = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // Snapshot stream.
  // s_tdata, low bit up: connected[0], button_bits[16:1],
  // trigger_left[31:17], trigger_right[46:32], stick_left_x[62:47],
  // stick_left_y[78:63], stick_right_x[94:79], stick_right_y[110:95], zero[111]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,
  // Result stream.
  // m_tdata, low bit up: is_connected[0], button_codes[32:1],
  // trigger_left_code[34:33], trigger_right_code[36:35], axis0_code[39:37],
  // axis1_code[42:40], axis2_code[45:43], axis3_code[48:46], zero[55:49]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,
  // Register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data
);

  // Configuration registers
  logic [LEVEL_W-1:0] press_level;
  logic [LEVEL_W-1:0] dead_level;

  // Input register
  snapshot_t in_q;
  logic      in_valid;
  logic      in_adv;

  // Result register
  result_t out_q;
  result_t result_next;

  key_phase_t  btn_next  [NUM_BUTTONS];
  key_phase_t  trg_next  [NUM_TRIGGERS];
  axis_phase_t axis_next_ph [NUM_AXES];

  logic [NUM_BUTTONS-1:0]          btn_pressed;
  logic [NUM_TRIGGERS-1:0]         trg_pressed;
  logic [NUM_AXES-1:0][AXIS_W-1:0] stick_in;
  logic                            update;

  // Writes are always taken; the user must write only while the block is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level <= PRESS_LEVEL_RESET;
      dead_level  <= DEAD_LEVEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRESS_LEVEL: press_level <= cfg_data;
        REG_DEAD_LEVEL:  dead_level  <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance the input register into the result register whenever the result
  // slot is empty or is being drained in this same cycle.
  assign in_adv   = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || in_adv;
  // Phases move only for connected snapshots.
  assign update   = in_adv && in_q.connected;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= snapshot_t'(s_tdata[$bits(snapshot_t)-1:0]);
    end
  end

  // Map snapshot fields onto the configured channel counts; extra channels
  // read as released or zero.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    if (i < IN_BUTTONS) begin : g_in
      assign btn_pressed[i] = in_q.button_bits[i];
    end else begin : g_zero
      assign btn_pressed[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_TRIGGERS; i++) begin : g_trg
    if (i < IN_TRIGGERS) begin : g_in
      assign trg_pressed[i] = in_q.trigger_level[i] > press_level;
    end else begin : g_zero
      assign trg_pressed[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    if (i < IN_AXES) begin : g_in
      assign stick_in[i] = in_q.stick_value[i];
    end else begin : g_zero
      assign stick_in[i] = '0;
    end
  end

  gpq_key_bank #(.N(NUM_BUTTONS)) u_buttons (
    .clk        (clk),
    .rst        (rst),
    .update     (update),
    .pressed    (btn_pressed),
    .phase_next (btn_next)
  );

  gpq_key_bank #(.N(NUM_TRIGGERS)) u_triggers (
    .clk        (clk),
    .rst        (rst),
    .update     (update),
    .pressed    (trg_pressed),
    .phase_next (trg_next)
  );

  gpq_axis_bank #(.N(NUM_AXES)) u_axes (
    .clk         (clk),
    .rst         (rst),
    .update      (update),
    .value       (stick_in),
    .press_level (press_level),
    .dead_level  (dead_level),
    .phase_next  (axis_next_ph)
  );

  // Assemble the result; a disconnected snapshot reports all codes as zero.
  always_comb begin
    result_next              = '0;
    result_next.is_connected = in_q.connected;
    if (in_q.connected) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (i < IN_BUTTONS) result_next.button_codes[2*i +: 2] = btn_next[i];
      end
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
        if (i < IN_TRIGGERS) result_next.trigger_code[i] = trg_next[i];
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        if (i < IN_AXES) result_next.axis_code[i] = axis_next_ph[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_q <= result_next;
    end
  end

  assign m_tdata = {(OUT_W - $bits(result_t))'(0), out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A disconnected result carries no codes.
  a_disconnected_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_q.is_connected) |->
      (out_q.button_codes == '0 && out_q.trigger_code == '0 && out_q.axis_code == '0))
    else $error("disconnected result carries nonzero codes");

  // An empty result slot never stalls the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result slot empty");

  // A snapshot moved forward always shows up as a pending result.
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    in_adv |=> m_tvalid)
    else $error("advanced snapshot lost");

  // The unused axis code never reaches the output.
  for (genvar i = 0; i < IN_AXES; i++) begin : g_axis_chk
    a_axis_code_legal: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> out_q.axis_code[i] != 3'd7)
      else $error("illegal axis code on output");
  end

endmodule
